// File: src/ipv4_fragment_tracker_macros.svh
// assertion macros for the ipv4 fragment tracker
// used at the end of the top level, expects i_clk and i_rst_n in scope
`ifndef IPV4_FRAGMENT_TRACKER_MACROS_SVH
`define IPV4_FRAGMENT_TRACKER_MACROS_SVH

// same-cycle implication, held off during reset
`define IFT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define IFT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/ift_pkg.sv
// shared types and constants for the ipv4 fragment tracker
// no dependencies; used by ift_front, ift_engine and the top level
package ift_pkg;

    localparam int SLOTS_DEF = 8;
    localparam int SLOT_W    = 4;
    localparam int IN_W      = 32;
    localparam int OUT_W     = 56;

    localparam logic [16:0] UNKNOWN_TOTAL = 17'h1FFFF;
    localparam logic [19:0] RECV_MAX      = 20'hFFFFF;

    typedef enum logic [2:0] {
        ST_HELD     = 3'd0,
        ST_DUP      = 3'd1,
        ST_TOO_MANY = 3'd2,
        ST_HOLE     = 3'd3,
        ST_COMPLETE = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        K_CLEAR = 2'd0,
        K_FIRST = 2'd1,
        K_LAST  = 2'd2,
        K_MID   = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] ofs;
        logic [15:0] len;
        logic [16:0] end_ofs;
    } t_frag;

endpackage

// File: src/ipv4_fragment_tracker.sv
// top level of the ipv4 fragment tracker: classifying front, fragment queue, tracking engine
// depends on ift_pkg, ift_front, ift_engine and ipv4_fragment_tracker_macros.svh
//
// channel | dir | tdata (low bit up)                              | tuser       | tlast
// s_axis  | in  | frag_word[15:0], payload_len[31:16]             | func        | -
// m_axis  | out | slot[3:0], piece_offset[19:4], piece_len[35:20],| status[2:0] | last
//         |     | total_payload[52:36], zero fill[55:53]          |             |
//
// a plain fragment is taken by the engine once it is idle and the result register is free
// on completion: a setup state, a backward walk of one slot per cycle, then the result
// words, or a single hole word if the walk fails, each once the result register is free
// the two-entry fragment queue keeps accepting words while the engine walks or waits, until full
// synchronous active-low reset clears all slots and the queue, no clearing pass
module ipv4_fragment_tracker #(
    parameter int SLOTS = ift_pkg::SLOTS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [ift_pkg::IN_W-1:0]  s_axis_tdata,   // frag_word, payload_len
    input  logic [0:0]                s_axis_tuser,   // func
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [ift_pkg::OUT_W-1:0] m_axis_tdata,   // slot, piece_offset, piece_len, total_payload
    output logic [2:0]                m_axis_tuser,   // status
    output logic                      m_axis_tlast    // last
);
    import ift_pkg::*;

    t_frag frag;
    logic  frag_valid;
    logic  frag_pop;

    ift_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_frag        (frag),
        .o_frag_valid  (frag_valid),
        .i_frag_pop    (frag_pop)
    );

    ift_engine #(
        .SLOTS (SLOTS)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frag        (frag),
        .i_frag_valid  (frag_valid),
        .o_frag_pop    (frag_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

`include "ipv4_fragment_tracker_macros.svh"

    // engine only takes a fragment that the queue holds
    `IFT_ASSERT_NOW(a_pop_valid, frag_pop, frag_valid, "fragment popped from empty queue")
    // anything but a completion is a single word
    `IFT_ASSERT_NOW(a_single, m_axis_tvalid && (m_axis_tuser != ST_COMPLETE), m_axis_tlast, "non-completion word without last")
    // the final piece is always the last fragment
    `IFT_ASSERT_NOW(a_tail_slot, m_axis_tvalid && m_axis_tlast && (m_axis_tuser == ST_COMPLETE), m_axis_tdata[3:0] == 4'd1, "completion does not end at slot one")
    // pieces of a completion follow each other without gaps
    `IFT_ASSERT_NEXT(a_burst, m_axis_tvalid && m_axis_tready && (m_axis_tuser == ST_COMPLETE) && !m_axis_tlast, m_axis_tvalid, "gap inside a completion burst")

endmodule

// File: src/ift_front.sv
// front end: takes input words, classifies each fragment and queues it
// depends on ift_pkg
module ift_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [ift_pkg::IN_W-1:0] s_axis_tdata,
    input  logic [0:0]            s_axis_tuser,
    output ift_pkg::t_frag        o_frag,
    output logic                  o_frag_valid,
    input  logic                  i_frag_pop
);
    import ift_pkg::*;

    localparam int QD = 2;

    t_frag       r_q [QD];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;
    t_frag       n_frag;
    logic        push;

    always_comb begin
        n_frag.ofs     = {s_axis_tdata[12:0], 3'b000};
        n_frag.len     = s_axis_tdata[31:16];
        n_frag.end_ofs = {1'b0, n_frag.ofs} + {1'b0, n_frag.len};
        if (s_axis_tuser[0]) begin
            n_frag.kind = K_CLEAR;
        end else if (n_frag.ofs == 16'd0) begin
            n_frag.kind = K_FIRST;
        end else if (!s_axis_tdata[13]) begin
            n_frag.kind = K_LAST;
        end else begin
            n_frag.kind = K_MID;
        end
    end

    assign s_axis_tready = (r_cnt < 2'(QD));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign o_frag        = r_q[r_rp];
    assign o_frag_valid  = (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_frag_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_frag_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_frag;
        end
    end

endmodule

// File: src/ift_engine.sv
// back end: slot store, duplicate check, backward walk and result register
// depends on ift_pkg
module ift_engine #(
    parameter int SLOTS = ift_pkg::SLOTS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ift_pkg::t_frag         i_frag,
    input  logic                   i_frag_valid,
    output logic                   o_frag_pop,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [ift_pkg::OUT_W-1:0] m_axis_tdata,
    output logic [2:0]             m_axis_tuser,
    output logic                   m_axis_tlast
);
    import ift_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_START = 6'b000010,
        S_WALK  = 6'b000100,
        S_HEAD  = 6'b001000,
        S_EMIT  = 6'b010000,
        S_FAIL  = 6'b100000
    } t_state;

    t_state         r_state;
    logic [SLOTS-1:0] r_valid;
    logic [15:0]    r_off [SLOTS];
    logic [15:0]    r_len [SLOTS];
    logic [CW-1:0]  r_next;
    logic [16:0]    r_exp;
    logic [19:0]    r_recv;

    logic [SLOTS-1:0] r_used;
    logic [IW-1:0]  r_chain [SLOTS];
    logic [CW-1:0]  r_ccnt;
    logic [IW-1:0]  r_i;
    logic [IW-1:0]  r_n;
    logic           r_moved;
    logic [16:0]    r_ofs;

    logic           r_ovalid;
    t_status        r_ostatus;
    logic [SLOT_W-1:0] r_oslot;
    logic [15:0]    r_ooff;
    logic [15:0]    r_olen;
    logic [16:0]    r_otot;
    logic           r_olast;

    logic           out_free;
    logic           pop;
    logic [SLOTS-1:0] dup_hit;
    logic [IW-1:0]  chain_top;
    logic [IW-1:0]  rd_idx;
    logic [15:0]    rd_off;
    logic [15:0]    rd_len;
    logic           hit;
    logic           n_store;
    logic           n_clear;
    logic           n_emit;
    t_status        n_status;
    logic [IW-1:0]  n_widx;
    logic [20:0]    recv_sum;
    logic [19:0]    n_recv;
    logic [16:0]    n_exp;
    logic           n_complete;
    logic           clr;

    assign out_free   = !r_ovalid || m_axis_tready;
    assign pop        = (r_state == S_IDLE) && i_frag_valid && out_free;
    assign o_frag_pop = pop;

    // one compare lane per slot for middle fragment duplicates
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            dup_hit[i] = r_valid[i] && (CW'(i) < r_next) && (r_off[i] == i_frag.ofs);
        end
    end

    assign chain_top = r_chain[IW'(r_ccnt - CW'(1))];
    assign rd_idx    = (r_state == S_EMIT) ? chain_top : r_i;
    assign rd_off    = r_off[rd_idx];
    assign rd_len    = r_len[rd_idx];
    assign hit       = !r_used[rd_idx] && (({1'b0, rd_off} + {1'b0, rd_len}) == r_ofs);

    assign recv_sum = {1'b0, r_recv} + {5'd0, i_frag.len};
    assign n_recv   = recv_sum[20] ? RECV_MAX : recv_sum[19:0];
    assign n_exp    = (i_frag.kind == K_LAST) ? i_frag.end_ofs : r_exp;

    always_comb begin
        n_store  = 1'b0;
        n_clear  = 1'b0;
        n_emit   = 1'b0;
        n_status = ST_HELD;
        n_widx   = '0;
        unique case (i_frag.kind)
            K_CLEAR: begin
                n_clear = 1'b1;
            end
            K_FIRST: begin
                if (r_valid[0]) begin
                    n_emit   = 1'b1;
                    n_status = ST_DUP;
                end else begin
                    n_store = 1'b1;
                end
            end
            K_LAST: begin
                if (r_valid[1]) begin
                    n_clear  = 1'b1;
                    n_emit   = 1'b1;
                    n_status = ST_TOO_MANY;
                end else begin
                    n_store = 1'b1;
                    n_widx  = IW'(1);
                end
            end
            K_MID: begin
                if (|dup_hit) begin
                    n_emit   = 1'b1;
                    n_status = ST_DUP;
                end else if (r_next >= CW'(SLOTS)) begin
                    n_clear  = 1'b1;
                    n_emit   = 1'b1;
                    n_status = ST_TOO_MANY;
                end else begin
                    n_store = 1'b1;
                    n_widx  = r_next[IW-1:0];
                end
            end
            default: begin
                n_store = 1'b0;
            end
        endcase
        n_complete = n_store && (n_exp != UNKNOWN_TOTAL) && (n_recv == {3'd0, n_exp})
                     && (r_valid[0] || (i_frag.kind == K_FIRST));
        if (n_store && !n_complete) begin
            n_emit = 1'b1;
        end
    end

    assign clr = (pop && n_clear)
              || ((r_state == S_EMIT) && out_free && (r_ccnt == CW'(1)))
              || ((r_state == S_FAIL) && out_free);

    always_ff @(posedge i_clk) begin
        if (pop && n_store) begin
            r_off[n_widx] <= i_frag.ofs;
            r_len[n_widx] <= i_frag.len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_next   <= CW'(2);
            r_exp    <= UNKNOWN_TOTAL;
            r_recv   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (pop) begin
                        if (n_store) begin
                            r_valid[n_widx] <= 1'b1;
                            r_recv          <= n_recv;
                            r_exp           <= n_exp;
                            if (i_frag.kind == K_MID) begin
                                r_next <= r_next + CW'(1);
                            end
                        end
                        if (n_emit) begin
                            r_ovalid  <= 1'b1;
                            r_ostatus <= n_status;
                            r_oslot   <= '0;
                            r_ooff    <= '0;
                            r_olen    <= '0;
                            r_otot    <= '0;
                            r_olast   <= 1'b1;
                        end
                        if (n_complete) begin
                            r_state <= S_START;
                        end
                    end
                end
                S_START: begin
                    // chain starts at the last fragment
                    r_used     <= ~r_valid | (SLOTS'(1) << 1);
                    r_ofs      <= {1'b0, r_off[1]};
                    r_n        <= IW'(r_next - CW'(1));
                    r_i        <= IW'(r_next - CW'(1));
                    r_moved    <= 1'b0;
                    r_chain[0] <= IW'(1);
                    r_ccnt     <= CW'(1);
                    r_state    <= S_WALK;
                end
                S_WALK: begin
                    if (r_ofs == {1'b0, r_len[0]}) begin
                        r_state <= S_HEAD;
                    end else begin
                        if (hit) begin
                            r_used[r_i]                <= 1'b1;
                            r_chain[r_ccnt[IW-1:0]]    <= r_i;
                            r_ccnt                     <= r_ccnt + CW'(1);
                            r_ofs                      <= {1'b0, rd_off};
                        end
                        if (r_i == IW'(1)) begin
                            // end of a sweep: restart or give up
                            if (hit || r_moved) begin
                                r_i     <= r_n;
                                r_moved <= 1'b0;
                            end else begin
                                r_state <= S_FAIL;
                            end
                        end else begin
                            r_i     <= r_i - IW'(1);
                            r_moved <= r_moved | hit;
                        end
                    end
                end
                S_HEAD: begin
                    if (out_free) begin
                        r_ovalid  <= 1'b1;
                        r_ostatus <= ST_COMPLETE;
                        r_oslot   <= '0;
                        r_ooff    <= r_off[0];
                        r_olen    <= r_len[0];
                        r_otot    <= r_exp;
                        r_olast   <= 1'b0;
                        r_state   <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_ovalid  <= 1'b1;
                        r_ostatus <= ST_COMPLETE;
                        r_oslot   <= SLOT_W'(chain_top);
                        r_ooff    <= rd_off;
                        r_olen    <= rd_len;
                        r_otot    <= r_exp;
                        r_olast   <= (r_ccnt == CW'(1));
                        r_ccnt    <= r_ccnt - CW'(1);
                        if (r_ccnt == CW'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_FAIL: begin
                    if (out_free) begin
                        r_ovalid  <= 1'b1;
                        r_ostatus <= ST_HOLE;
                        r_oslot   <= '0;
                        r_ooff    <= '0;
                        r_olen    <= '0;
                        r_otot    <= '0;
                        r_olast   <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (clr) begin
                r_valid <= '0;
                r_next  <= CW'(2);
                r_exp   <= UNKNOWN_TOTAL;
                r_recv  <= '0;
            end
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {3'd0, r_otot, r_olen, r_ooff, r_oslot};
    assign m_axis_tuser  = r_ostatus;
    assign m_axis_tlast  = r_olast;

endmodule
